[sv/assert_macros.svh]
// Assertion macros used by the back-end RTL module of the framed message receiver.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Checks that a property holds at every rising clock edge outside reset.
`define CHK_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Checks that a condition never holds at a rising clock edge outside reset.
`define CHK_NEVER(lbl, clk, rstn, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

`else

`define CHK_ASSERT(lbl, clk, rstn, prop, msg)
`define CHK_NEVER(lbl, clk, rstn, cond, msg)

`endif

`endif

[sv/mfr_pkg.sv]
// Package with the types, constants and helpers of the framed message receiver.
package mfr_pkg;

    localparam int FIFO_DEPTH  = 64;
    localparam int FIFO_AW     = $clog2(FIFO_DEPTH);
    localparam int FILL_W      = FIFO_AW + 1;
    localparam int NEED_W      = 7;
    localparam int CMP_W       = (FILL_W > NEED_W) ? FILL_W : NEED_W;
    localparam logic [FIFO_AW:0] DEPTH_V = (FIFO_AW + 1)'(FIFO_DEPTH);

    localparam int CMDQ_DEPTH  = 2;
    localparam int CMDQ_AW     = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
    localparam int CMDQ_CW     = $clog2(CMDQ_DEPTH + 1);

    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 8;

    localparam logic [CFG_IDX_W-1:0] REG_START_MARKER = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_END_MARKER   = 1'd1;

    localparam logic [7:0] START_MARKER_RST = 8'd60;
    localparam logic [7:0] END_MARKER_RST   = 8'd62;

    localparam logic [1:0] MODE_BYTE    = 2'd0;
    localparam logic [1:0] MODE_TICK    = 2'd1;
    localparam logic [1:0] MODE_REQUEST = 2'd2;

    localparam logic [1:0] ST_SUCCESS = 2'd0;
    localparam logic [1:0] ST_NOMSG   = 2'd1;
    localparam logic [1:0] ST_FRAMING = 2'd2;
    localparam logic [1:0] ST_TIMEOUT = 2'd3;

    localparam logic       KIND_PAYLOAD = 1'b0;
    localparam logic       KIND_STATUS  = 1'b1;

    // A length of this value can never form a complete frame.
    localparam logic [5:0] LEN_NEVER = 6'd63;
    localparam logic [15:0] TICKS_MAX = 16'hFFFF;

    typedef struct packed {
        logic [1:0]  mode;
        logic [7:0]  rx_byte;
        logic [5:0]  msg_length;
        logic [15:0] timeout_ticks;
    } in_beat_t;

    typedef struct packed {
        logic       kind;
        logic [7:0] payload;
        logic [1:0] status;
        logic       last;
    } out_beat_t;

    typedef enum logic [1:0] {
        OP_BYTE,
        OP_TICK,
        OP_REQ
    } cmd_op_t;

    typedef struct packed {
        cmd_op_t     op;
        logic [7:0]  data;
        logic [5:0]  len;
        logic [15:0] timeout;
    } cmd_t;

    // Adds an offset below the depth to a FIFO index and wraps once.
    function automatic logic [FIFO_AW-1:0] wrap_add(input logic [FIFO_AW-1:0] base,
                                                    input logic [FIFO_AW-1:0] off);
        logic [FIFO_AW:0] sum;
        sum = {1'b0, base} + {1'b0, off};
        if (sum >= DEPTH_V)
        begin
            sum = sum - DEPTH_V;
        end
        return sum[FIFO_AW-1:0];
    endfunction

endpackage

[sv/mfr_front.sv]
// Front end: takes input beats, classifies them and queues commands for the back end.
module mfr_front
    import mfr_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  in_beat_t in_data,
    output logic     cmd_valid,
    input  logic     cmd_pop,
    output cmd_t     cmd
);

    cmd_t                 queue_mem [CMDQ_DEPTH];
    logic [CMDQ_AW-1:0]   wr_ptr_reg;
    logic [CMDQ_AW-1:0]   wr_ptr_next;
    logic [CMDQ_AW-1:0]   rd_ptr_reg;
    logic [CMDQ_AW-1:0]   rd_ptr_next;
    logic [CMDQ_CW-1:0]   count_reg;
    logic [CMDQ_CW-1:0]   count_next;
    logic                 accept;
    logic                 push;
    logic                 pop;
    cmd_t                 new_cmd;

    assign in_ready  = (count_reg != CMDQ_CW'(CMDQ_DEPTH));
    assign cmd_valid = (count_reg != '0);
    assign cmd       = queue_mem[rd_ptr_reg];
    assign accept    = in_valid && in_ready;
    assign pop       = cmd_pop && cmd_valid;

    // The unused mode is accepted and dropped here, so it never reaches the back end.
    always_comb
    begin
        new_cmd.data    = in_data.rx_byte;
        new_cmd.len     = in_data.msg_length;
        new_cmd.timeout = in_data.timeout_ticks;
        new_cmd.op      = OP_BYTE;
        push            = 1'b0;
        case (in_data.mode)
            MODE_BYTE:
            begin
                new_cmd.op = OP_BYTE;
                push       = accept;
            end
            MODE_TICK:
            begin
                new_cmd.op = OP_TICK;
                push       = accept;
            end
            MODE_REQUEST:
            begin
                new_cmd.op = OP_REQ;
                push       = accept;
            end
            default:
            begin
                push = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == CMDQ_AW'(CMDQ_DEPTH - 1)) ? '0
                                                                    : wr_ptr_reg + CMDQ_AW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == CMDQ_AW'(CMDQ_DEPTH - 1)) ? '0
                                                                    : rd_ptr_reg + CMDQ_AW'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CMDQ_CW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CMDQ_CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_mem[wr_ptr_reg] <= new_cmd;
        end
    end

endmodule

[sv/mfr_back.sv]
// Back end: byte FIFO, request tracking, frame check, payload output and resync.
`include "assert_macros.svh"

module mfr_back
    import mfr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cmd_valid,
    output logic       cmd_pop,
    input  cmd_t       cmd,
    input  logic [7:0] start_marker,
    input  logic [7:0] end_marker,
    output logic       out_valid,
    input  logic       out_ready,
    output out_beat_t  out_data
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_HEAD,
        S_TAIL,
        S_EMIT,
        S_PAYLOAD,
        S_RESYNC,
        S_RESYNC_CMP,
        S_STATUS
    } state_t;

    logic [7:0]          byte_mem [FIFO_DEPTH];
    logic [7:0]          rd_data_reg;

    state_t              state_reg, state_next;
    logic [FIFO_AW-1:0]  head_reg, head_next;
    logic [FILL_W-1:0]   fill_reg, fill_next;
    logic                pending_reg, pending_next;
    logic [5:0]          len_reg, len_next;
    logic [15:0]         timeout_reg, timeout_next;
    logic [15:0]         elapsed_reg, elapsed_next;
    logic [5:0]          remain_reg, remain_next;
    logic [1:0]          status_reg, status_next;
    logic                start_ok_reg, start_ok_next;
    logic                out_valid_reg, out_valid_next;
    out_beat_t           out_data_reg, out_data_next;

    logic                mem_we;
    logic [FIFO_AW-1:0]  wr_addr;
    logic                mem_re;
    logic [FIFO_AW-1:0]  rd_addr;
    logic                can_load;
    logic [FIFO_AW-1:0]  head_inc;
    logic [FILL_W-1:0]   fill_dec;
    logic [15:0]         elapsed_inc;
    logic [NEED_W-1:0]   need;
    logic [NEED_W-1:0]   tail_off;

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign can_load    = !out_valid_reg || out_ready;
    assign head_inc    = wrap_add(head_reg, FIFO_AW'(1));
    assign fill_dec    = fill_reg - FILL_W'(1);
    assign elapsed_inc = (elapsed_reg < TICKS_MAX) ? elapsed_reg + 16'd1 : elapsed_reg;
    assign need        = {1'b0, len_reg} + NEED_W'(2);
    assign tail_off    = {1'b0, len_reg} + NEED_W'(1);

    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        fill_next      = fill_reg;
        pending_next   = pending_reg;
        len_next       = len_reg;
        timeout_next   = timeout_reg;
        elapsed_next   = elapsed_reg;
        remain_next    = remain_reg;
        status_next    = status_reg;
        start_ok_next  = start_ok_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        mem_we         = 1'b0;
        wr_addr        = head_reg;
        mem_re         = 1'b0;
        rd_addr        = head_reg;
        cmd_pop        = 1'b0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_pop = 1'b1;
                    case (cmd.op)
                        OP_BYTE:
                        begin
                            mem_we = 1'b1;
                            if (fill_reg == DEPTH_V)
                            begin
                                // Full: the new byte takes the slot of the oldest one.
                                wr_addr   = head_reg;
                                head_next = head_inc;
                            end
                            else
                            begin
                                wr_addr   = wrap_add(head_reg, FIFO_AW'(fill_reg));
                                fill_next = fill_reg + FILL_W'(1);
                            end
                            if (pending_reg)
                            begin
                                state_next = S_CHECK;
                            end
                        end
                        OP_TICK:
                        begin
                            if (pending_reg)
                            begin
                                elapsed_next = elapsed_inc;
                                if (elapsed_inc >= timeout_reg)
                                begin
                                    pending_next = 1'b0;
                                    status_next  = ST_TIMEOUT;
                                    state_next   = S_STATUS;
                                end
                            end
                        end
                        OP_REQ:
                        begin
                            pending_next = 1'b0;
                            if (fill_reg == '0)
                            begin
                                status_next = ST_NOMSG;
                                state_next  = S_STATUS;
                            end
                            else
                            begin
                                len_next     = cmd.len;
                                timeout_next = cmd.timeout;
                                elapsed_next = 16'd0;
                                if (cmd.timeout == 16'd0)
                                begin
                                    status_next = ST_TIMEOUT;
                                    state_next  = S_STATUS;
                                end
                                else
                                begin
                                    pending_next = 1'b1;
                                    state_next   = S_CHECK;
                                end
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_CHECK:
            begin
                if (len_reg != LEN_NEVER && CMP_W'(fill_reg) >= CMP_W'(need))
                begin
                    pending_next = 1'b0;
                    mem_re       = 1'b1;
                    rd_addr      = head_reg;
                    state_next   = S_HEAD;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_HEAD:
            begin
                start_ok_next = (rd_data_reg == start_marker);
                mem_re        = 1'b1;
                rd_addr       = wrap_add(head_reg, FIFO_AW'(tail_off));
                state_next    = S_TAIL;
            end
            S_TAIL:
            begin
                head_next = head_inc;
                fill_next = fill_dec;
                if (start_ok_reg && rd_data_reg == end_marker)
                begin
                    remain_next = len_reg;
                    state_next  = S_EMIT;
                end
                else
                begin
                    state_next = S_RESYNC;
                end
            end
            S_EMIT:
            begin
                if (remain_reg == '0)
                begin
                    head_next   = head_inc;
                    fill_next   = fill_dec;
                    status_next = ST_SUCCESS;
                    state_next  = S_STATUS;
                end
                else
                begin
                    mem_re     = 1'b1;
                    rd_addr    = head_reg;
                    state_next = S_PAYLOAD;
                end
            end
            S_PAYLOAD:
            begin
                if (can_load)
                begin
                    out_valid_next        = 1'b1;
                    out_data_next.kind    = KIND_PAYLOAD;
                    out_data_next.payload = rd_data_reg;
                    out_data_next.status  = ST_SUCCESS;
                    out_data_next.last    = 1'b0;
                    head_next             = head_inc;
                    fill_next             = fill_dec;
                    remain_next           = remain_reg - 6'd1;
                    state_next            = S_EMIT;
                end
            end
            S_RESYNC:
            begin
                if (fill_reg == '0)
                begin
                    status_next = ST_FRAMING;
                    state_next  = S_STATUS;
                end
                else
                begin
                    mem_re     = 1'b1;
                    rd_addr    = head_reg;
                    state_next = S_RESYNC_CMP;
                end
            end
            S_RESYNC_CMP:
            begin
                if (rd_data_reg == start_marker)
                begin
                    status_next = ST_FRAMING;
                    state_next  = S_STATUS;
                end
                else
                begin
                    head_next  = head_inc;
                    fill_next  = fill_dec;
                    state_next = S_RESYNC;
                end
            end
            S_STATUS:
            begin
                if (can_load)
                begin
                    out_valid_next        = 1'b1;
                    out_data_next.kind    = KIND_STATUS;
                    out_data_next.payload = 8'd0;
                    out_data_next.status  = status_reg;
                    out_data_next.last    = 1'b1;
                    state_next            = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            fill_reg      <= '0;
            pending_reg   <= 1'b0;
            len_reg       <= '0;
            timeout_reg   <= '0;
            elapsed_reg   <= '0;
            remain_reg    <= '0;
            status_reg    <= ST_SUCCESS;
            start_ok_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            fill_reg      <= fill_next;
            pending_reg   <= pending_next;
            len_reg       <= len_next;
            timeout_reg   <= timeout_next;
            elapsed_reg   <= elapsed_next;
            remain_reg    <= remain_next;
            status_reg    <= status_next;
            start_ok_reg  <= start_ok_next;
            out_valid_reg <= out_valid_next;
            out_data_reg  <= out_data_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            byte_mem[wr_addr] <= cmd.data;
        end
        if (mem_re)
        begin
            rd_data_reg <= byte_mem[rd_addr];
        end
    end

    `CHK_NEVER(a_fill_in_range, clk, rst_n, fill_reg > DEPTH_V, "FIFO fill count exceeds depth")
    `CHK_NEVER(a_read_empty, clk, rst_n, mem_re && fill_reg == '0, "FIFO read while empty")
    `CHK_ASSERT(a_last_on_status, clk, rst_n, out_valid_reg |-> (out_data_reg.kind == out_data_reg.last), "last flag does not match result kind")
    `CHK_ASSERT(a_no_pending_emit, clk, rst_n, (state_reg == S_EMIT || state_reg == S_PAYLOAD || state_reg == S_RESYNC) |-> !pending_reg, "request still pending after frame check")

endmodule

[sv/marker_framed_message_receiver.sv]
// Top level of the marker-framed message receiver: configuration registers and wiring.
//
// Input beats carry a mode: a received byte, a one millisecond tick or a message
// request with a payload length and a timeout in ticks. Result beats carry either a
// payload byte or the request status; the last flag marks the final beat of a request.
// Both channels use valid and ready; start and end markers are written through a
// plain write port (index 0 start marker, index 1 end marker). The user must write
// them only while the block is idle; the block itself does not enforce this.
// The front end accepts beats into a two-entry command queue, so input is taken while
// results wait downstream. The back end executes one command at a time: a byte or
// tick is handled in S_IDLE; a frame check passes S_CHECK, S_HEAD and S_TAIL; each
// payload byte is read from the FIFO memory port in S_EMIT and sent in S_PAYLOAD, and
// the closing status goes out from S_STATUS; a resync steps through S_RESYNC and
// S_RESYNC_CMP for each dropped byte, since the byte FIFO has a single read port.
// Results pass through an output register.
// Reset empties the FIFO, clears any pending request and sets the markers to 60 and 62.
// When the receiver stalls, the output register holds its beat, the back end waits,
// and once the queue fills, in_ready drops until results drain.
module marker_framed_message_receiver
    import mfr_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  in_beat_t              in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output out_beat_t             out_data,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic [7:0] start_marker_reg;
    logic [7:0] end_marker_reg;
    logic       cmd_valid;
    logic       cmd_pop;
    cmd_t       cmd;

    // The user must write the marker registers only while the block is idle, so the
    // back end can compare against them directly; the block does not enforce this.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_marker_reg <= START_MARKER_RST;
            end_marker_reg   <= END_MARKER_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_START_MARKER:
                begin
                    start_marker_reg <= cfg_data;
                end
                REG_END_MARKER:
                begin
                    end_marker_reg <= cfg_data;
                end
                default:
                begin
                    start_marker_reg <= start_marker_reg;
                end
            endcase
        end
    end

    // The front end classifies each beat and queues it as a command.
    mfr_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .cmd_valid (cmd_valid),
        .cmd_pop   (cmd_pop),
        .cmd       (cmd)
    );

    // The back end owns the byte FIFO, the pending request and the result register.
    mfr_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_valid    (cmd_valid),
        .cmd_pop      (cmd_pop),
        .cmd          (cmd),
        .start_marker (start_marker_reg),
        .end_marker   (end_marker_reg),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_data     (out_data)
    );

endmodule

[verif/frame_result_checker.sv]
// Checker that mirrors the framed message receiver and scores its result beats.
`timescale 1ns / 1ps

module frame_result_checker
    import mfr_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  in_ready,
    input  in_beat_t              in_data,
    input  logic                  out_valid,
    input  logic                  out_ready,
    input  out_beat_t             out_data,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    fail_count,
    output int                    results_owed,
    output int                    frames_ok,
    output int                    payload_seen,
    output int                    framing_seen,
    output int                    timeout_seen,
    output int                    nomsg_seen
);

    // Mirror of the receiver state.
    logic [7:0]         fifo_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] head;
    logic [FILL_W-1:0]  fill;
    logic               req_waiting;
    logic [5:0]         pend_len;
    logic [15:0]        pend_ticks;
    logic [15:0]        ticks_seen;
    logic [7:0]         start_mk;
    logic [7:0]         end_mk;

    out_beat_t owed [$];
    int        mismatches = 0;

    assign fail_count = mismatches;

    function automatic logic [7:0] byte_at(input int off);
        return fifo_mem[(int'(head) + off) % FIFO_DEPTH];
    endfunction

    function automatic void drop_oldest();
        if (fill == 0)
        begin
            return;
        end
        head = FIFO_AW'((int'(head) + 1) % FIFO_DEPTH);
        fill = fill - FILL_W'(1);
    endfunction

    function automatic void store_byte(input logic [7:0] b);
        if (int'(fill) >= FIFO_DEPTH)
        begin
            drop_oldest();
        end
        fifo_mem[(int'(head) + int'(fill)) % FIFO_DEPTH] = b;
        fill = fill + FILL_W'(1);
    endfunction

    function automatic void owe(input logic kind, input logic [7:0] data,
                                input logic [1:0] st, input logic last);
        out_beat_t r;
        r.kind    = kind;
        r.payload = data;
        r.status  = st;
        r.last    = last;
        owed.push_back(r);
    endfunction

    // Once enough bytes are buffered, either deliver the frame or resync to the
    // next start marker.
    function automatic void check_frame_now();
        int n;
        int i;
        n = int'(pend_len);
        if (n >= int'(LEN_NEVER) || int'(fill) < n + 2)
        begin
            return;
        end
        req_waiting = 1'b0;
        if (byte_at(0) == start_mk && byte_at(n + 1) == end_mk)
        begin
            drop_oldest();
            for (i = 0; i < n; i++)
            begin
                owe(KIND_PAYLOAD, byte_at(0), '0, 1'b0);
                drop_oldest();
            end
            drop_oldest();
            owe(KIND_STATUS, '0, ST_SUCCESS, 1'b1);
        end
        else
        begin
            drop_oldest();
            while (fill != 0 && byte_at(0) != start_mk)
            begin
                drop_oldest();
            end
            owe(KIND_STATUS, '0, ST_FRAMING, 1'b1);
        end
    endfunction

    function automatic void apply_beat(input in_beat_t b);
        case (b.mode)
            MODE_BYTE:
            begin
                store_byte(b.rx_byte);
                if (req_waiting)
                begin
                    check_frame_now();
                end
            end
            MODE_TICK:
            begin
                if (req_waiting)
                begin
                    if (ticks_seen < TICKS_MAX)
                    begin
                        ticks_seen = ticks_seen + 16'd1;
                    end
                    if (ticks_seen >= pend_ticks)
                    begin
                        req_waiting = 1'b0;
                        owe(KIND_STATUS, '0, ST_TIMEOUT, 1'b1);
                    end
                end
            end
            MODE_REQUEST:
            begin
                req_waiting = 1'b0;
                if (fill == 0)
                begin
                    owe(KIND_STATUS, '0, ST_NOMSG, 1'b1);
                end
                else
                begin
                    pend_len   = b.msg_length;
                    pend_ticks = b.timeout_ticks;
                    ticks_seen = '0;
                    if (pend_ticks == 0)
                    begin
                        owe(KIND_STATUS, '0, ST_TIMEOUT, 1'b1);
                    end
                    else
                    begin
                        req_waiting = 1'b1;
                        check_frame_now();
                    end
                end
            end
            default:
            begin
            end
        endcase
    endfunction

    function automatic void compare_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : score
        out_beat_t want;
        if (!rst_n)
        begin
            head         = '0;
            fill         = '0;
            req_waiting  = 1'b0;
            pend_len     = '0;
            pend_ticks   = '0;
            ticks_seen   = '0;
            start_mk     = START_MARKER_RST;
            end_mk       = END_MARKER_RST;
            owed.delete();
            frames_ok    = 0;
            payload_seen = 0;
            framing_seen = 0;
            timeout_seen = 0;
            nomsg_seen   = 0;
            results_owed <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_START_MARKER: start_mk = cfg_data;
                    REG_END_MARKER:   end_mk = cfg_data;
                    default:
                    begin
                    end
                endcase
            end
            if (out_valid && out_ready)
            begin
                if (owed.size() == 0)
                begin
                    $error("unexpected result: kind %0d payload %0d status %0d last %0d",
                           out_data.kind, out_data.payload, out_data.status, out_data.last);
                    mismatches++;
                end
                else
                begin
                    want = owed.pop_front();
                    compare_field("kind", want.kind, out_data.kind);
                    compare_field("payload", want.payload, out_data.payload);
                    compare_field("status", want.status, out_data.status);
                    compare_field("last", want.last, out_data.last);
                end
                if (out_data.kind == KIND_PAYLOAD)
                begin
                    payload_seen++;
                end
                else
                begin
                    case (out_data.status)
                        ST_SUCCESS: frames_ok++;
                        ST_NOMSG:   nomsg_seen++;
                        ST_FRAMING: framing_seen++;
                        default:    timeout_seen++;
                    endcase
                end
            end
            if (in_valid && in_ready)
            begin
                apply_beat(in_data);
            end
            results_owed <= owed.size();
        end
    end

endmodule

[verif/tb_marker_framed_message_receiver.sv]
// Testbench top for the marker-framed message receiver: stimulus, pacing and verdict.
`timescale 1ns / 1ps

module tb_marker_framed_message_receiver;
    import mfr_pkg::*;

    // Mode 3 has no meaning to the block; it must be swallowed silently.
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    localparam int PHASES        = 5;
    localparam int PHASE_BEATS   = 82;
    localparam int IDLE_LIMIT    = 5000;
    localparam int HOLD_AT       = 200;
    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = 16;
    localparam int TAIL_CYCLES   = 40;

    // Ways a frame sequence can be spoiled on purpose.
    typedef enum int {FLAW_NONE, FLAW_LEAD_JUNK, FLAW_BAD_END, FLAW_CUT_SHORT} flaw_t;

    // Receiver pacing styles: always ready, coin toss, and one cycle in four.
    typedef enum int {PACE_OPEN, PACE_COIN, PACE_SPARSE} pace_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    in_beat_t              in_data = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    out_beat_t             out_data;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = REG_START_MARKER;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    int fail_count;
    int results_owed;
    int frames_ok;
    int payload_seen;
    int framing_seen;
    int timeout_seen;
    int nomsg_seen;

    // Stimulus bookkeeping. The markers here track what was last written so
    // that generated frames use the live values.
    logic [7:0] cur_start = START_MARKER_RST;
    logic [7:0] cur_end = END_MARKER_RST;
    int         beats_sent = 0;
    int         burst_left = 0;
    int         quiet_cycles = 0;
    bit         hold_done = 1'b0;

    always #5 clk = ~clk;

    marker_framed_message_receiver uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    frame_result_checker chk (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .in_data      (in_data),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_data     (out_data),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .fail_count   (fail_count),
        .results_owed (results_owed),
        .frames_ok    (frames_ok),
        .payload_seen (payload_seen),
        .framing_seen (framing_seen),
        .timeout_seen (timeout_seen),
        .nomsg_seen   (nomsg_seen)
    );

    // Offers one beat and holds it until the block takes it. The sender works
    // in bursts: when a burst runs out, valid may drop for a random gap before
    // the next burst begins. Within a burst valid stays high across beats, so
    // it is never lowered and raised in the same time step.
    task automatic send_beat(input in_beat_t beat);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 80)
                                                     : $urandom_range(1, 12);
        end
        in_valid <= 1'b1;
        in_data  <= beat;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        burst_left--;
        if (beat.mode != MODE_UNUSED)
        begin
            beats_sent++;
        end
    endtask

    // Fields a mode does not use are filled with noise, which the block must ignore.
    task automatic push_rx(input logic [7:0] b);
        in_beat_t beat;
        beat.mode          = MODE_BYTE;
        beat.rx_byte       = b;
        beat.msg_length    = 6'($urandom_range(0, 63));
        beat.timeout_ticks = 16'($urandom_range(0, 65535));
        send_beat(beat);
    endtask

    task automatic tick();
        in_beat_t beat;
        beat.mode          = MODE_TICK;
        beat.rx_byte       = 8'($urandom_range(0, 255));
        beat.msg_length    = 6'($urandom_range(0, 63));
        beat.timeout_ticks = 16'($urandom_range(0, 65535));
        send_beat(beat);
    endtask

    task automatic request(input logic [5:0] len, input logic [15:0] ticks);
        in_beat_t beat;
        beat.mode          = MODE_REQUEST;
        beat.rx_byte       = 8'($urandom_range(0, 255));
        beat.msg_length    = len;
        beat.timeout_ticks = ticks;
        send_beat(beat);
    endtask

    task automatic ignored_beat();
        in_beat_t beat;
        beat.mode          = MODE_UNUSED;
        beat.rx_byte       = 8'($urandom_range(0, 255));
        beat.msg_length    = 6'($urandom_range(0, 63));
        beat.timeout_ticks = 16'($urandom_range(0, 65535));
        send_beat(beat);
    endtask

    // Mostly short frames keep the run quick; now and then a long one, with 40 to 62
    // payload bytes, brings the FIFO near or right up to its depth.
    function automatic logic [5:0] pick_len();
        return ($urandom_range(0, 15) == 0) ? 6'($urandom_range(40, 62))
                                            : 6'($urandom_range(0, 8));
    endfunction

    // Sends one frame with random payload. The request goes either ahead of the
    // body, so the block checks after every byte, or behind it, so the frame is
    // checked at once. Stray ticks and the odd repeated request are mixed in.
    task automatic send_frame(input flaw_t flaw);
        logic [5:0]  len;
        logic [15:0] ticks;
        bit          req_first;
        int          cut;
        int          i;
        len       = pick_len();
        ticks     = ($urandom_range(0, 3) == 0) ? TICKS_MAX : 16'($urandom_range(80, 65534));
        req_first = $urandom_range(0, 1);
        cut       = len;
        if (flaw == FLAW_CUT_SHORT)
        begin
            // The body stops early and the request is left to run out of ticks.
            if (len == 0)
            begin
                len = 6'd1;
            end
            ticks     = 16'($urandom_range(1, 6));
            req_first = 1'b1;
            cut       = $urandom_range(0, len - 1);
        end
        if (flaw == FLAW_LEAD_JUNK)
        begin
            repeat ($urandom_range(1, 3)) push_rx(8'($urandom_range(0, 255)));
        end
        push_rx(cur_start);
        if (req_first)
        begin
            request(len, ticks);
        end
        for (i = 0; i < cut; i++)
        begin
            push_rx(8'($urandom_range(0, 255)));
            if ($urandom_range(0, 7) == 0)
            begin
                tick();
            end
            if (req_first && $urandom_range(0, 39) == 0)
            begin
                request(len, ticks);
            end
        end
        if (flaw == FLAW_CUT_SHORT)
        begin
            repeat (int'(ticks)) tick();
        end
        else
        begin
            push_rx((flaw == FLAW_BAD_END) ? cur_end ^ 8'($urandom_range(1, 255)) : cur_end);
            if (!req_first)
            begin
                request(len, ticks);
            end
        end
    endtask

    // Brings the block to rest. A request with a zero timeout ends any request
    // still waiting, whatever the FIFO holds; after its status beat arrives a
    // settling wait lets trailing byte and tick beats finish in the back end.
    task automatic drain_requests();
        request(6'($urandom_range(0, 63)), 16'd0);
        in_valid <= 1'b0;
        burst_left = 0;
        do @(posedge clk); while (results_owed != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Receiver pacing. It switches between open stretches, coin-toss stalls
    // and a sparse one-in-four pattern. Once, well into the run, it refuses
    // results for a long stretch while the sender keeps offering beats, so the
    // output register and command queue fill and in_ready has to drop.
    initial
    begin : rx_pacing
        pace_t pace;
        int    span;
        int    k;
        wait (rst_n);
        forever
        begin
            if (!hold_done && beats_sent >= HOLD_AT)
            begin
                hold_done = 1'b1;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                pace = pace_t'($urandom_range(0, 2));
                span = $urandom_range(8, 64);
                for (k = 0; k < span; k++)
                begin
                    case (pace)
                        PACE_OPEN: out_ready <= 1'b1;
                        PACE_COIN: out_ready <= ($urandom_range(0, 1) == 1);
                        default:   out_ready <= (k % 4 == 3);
                    endcase
                    @(posedge clk);
                end
            end
        end
    end

    // Watchdog: a long run of cycles with no beat moving on either channel
    // means the block has hung or lost results.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
            begin
                quiet_cycles <= 0;
            end
            else if (quiet_cycles >= IDLE_LIMIT)
            begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
            else
            begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    initial
    begin : stimulus
        int         ph;
        int         phase_start;
        int         pick;
        logic [7:0] m;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Directed opening, with the markers at their reset values.
        // A tick with nothing waiting does nothing; a request on an empty FIFO
        // answers no-message at once, even with the longest length and timeout.
        tick();
        request(LEN_NEVER, TICKS_MAX);
        ignored_beat();
        // A zero timeout with bytes buffered times out immediately.
        push_rx(8'h00);
        request(6'd0, 16'd0);
        // Garbage ahead of the frame gives a framing error and the resync
        // empties the FIFO, since no start marker follows.
        request(6'd0, 16'd2);
        push_rx(8'hFF);
        // A second request replaces the first; only the second gets a reply,
        // here an empty frame of just the two markers.
        push_rx(cur_start);
        request(6'd1, 16'd3);
        tick();
        tick();
        request(6'd0, 16'd5);
        push_rx(cur_end);
        // A length that can never complete waits until its ticks run out.
        push_rx(cur_start);
        request(LEN_NEVER, 16'd2);
        push_rx(8'hAA);
        push_rx(cur_end);
        tick();
        tick();
        // The same buffered bytes then make a good one-byte frame.
        request(6'd1, 16'd1);
        tick();

        // Random phases, each under its own pair of markers: the reset pair,
        // both extremes each way round, a random pair and one shared value.
        for (ph = 0; ph < PHASES; ph++)
        begin
            if (ph > 0)
            begin
                drain_requests();
                m = 8'($urandom_range(0, 255));
                case (ph)
                    1:       begin cur_start = 8'h00; cur_end = 8'hFF; end
                    2:       begin cur_start = 8'hFF; cur_end = 8'h00; end
                    3:       begin cur_start = m; cur_end = 8'($urandom_range(0, 255)); end
                    default: begin cur_start = m; cur_end = m; end
                endcase
                cfg_we    <= 1'b1;
                cfg_index <= REG_START_MARKER;
                cfg_data  <= cur_start;
                @(posedge clk);
                cfg_index <= REG_END_MARKER;
                cfg_data  <= cur_end;
                @(posedge clk);
                cfg_we    <= 1'b0;
            end
            phase_start = beats_sent;
            while (beats_sent - phase_start < PHASE_BEATS)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 58)
                begin
                    send_frame(FLAW_NONE);
                end
                else if (pick < 74)
                begin
                    send_frame(flaw_t'($urandom_range(1, 3)));
                end
                else if (pick < 86)
                begin
                    repeat ($urandom_range(1, 4))
                    begin
                        if ($urandom_range(0, 1) == 1)
                        begin
                            push_rx(8'($urandom_range(0, 255)));
                        end
                        else
                        begin
                            tick();
                        end
                    end
                end
                else if (pick < 91)
                begin
                    ignored_beat();
                end
                else if (pick < 97)
                begin
                    case ($urandom_range(0, 2))
                        0:       request(6'($urandom_range(0, 63)), 16'd0);
                        1:       request(6'($urandom_range(0, 63)), TICKS_MAX);
                        default: request(6'($urandom_range(0, 63)),
                                         16'($urandom_range(1, 65535)));
                    endcase
                end
                else
                begin
                    // A flood of bytes overruns the FIFO so the oldest get dropped.
                    repeat ($urandom_range(66, 72)) push_rx(8'($urandom_range(0, 255)));
                end
            end
        end

        drain_requests();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Run covered %0d input beats under %0d marker pairs, with a long output stall.",
                 beats_sent, PHASES);
        $display("Seen: %0d frames (%0d payload bytes), %0d framing errors, %0d timeouts, %0d empty.",
                 frames_ok, payload_seen, framing_seen, timeout_seen, nomsg_seen);
        if (fail_count == 0 && results_owed == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

[marker_framed_message_receiver.f]
+incdir+sv
sv/mfr_pkg.sv
sv/mfr_front.sv
sv/mfr_back.sv
sv/marker_framed_message_receiver.sv
verif/frame_result_checker.sv
verif/tb_marker_framed_message_receiver.sv
